// ===== sv/s7rmn_pkg.sv =====
package s7rmn_pkg;

    localparam int DEF_MAX_GRID      = 64;
    localparam int DEF_FRACTION_BITS = 16;
    localparam int GRID_RESET        = 64;
    localparam int CFG_W             = 7;
    localparam int FIELD_W           = 32;
    localparam int NORM_W            = 48;
    localparam int PROD_W            = 2 * FIELD_W;
    localparam int ACC_W             = PROD_W + 3;
    localparam int JOBQ_DEPTH        = 4;
    localparam int CELL_W            = 6 * FIELD_W;

    // field offsets inside one window word
    localparam int OFS_RHS   = 0;
    localparam int OFS_X     = FIELD_W;
    localparam int OFS_FRONT = 2 * FIELD_W;
    localparam int OFS_UP    = 3 * FIELD_W;
    localparam int OFS_RIGHT = 4 * FIELD_W;
    localparam int OFS_DIAG  = 5 * FIELD_W;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_COUPLING  = 2'd1,
        ERR_ZERO_DIAG = 2'd2
    } err_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // three planes of slack plus the jobs in flight
    function automatic int win_depth(input int max_grid);
        return 3 * max_grid * max_grid + JOBQ_DEPTH + 4;
    endfunction

endpackage

// ===== sv/s7rmn_ram.sv =====
module s7rmn_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/s7rmn_jobq.sv =====
module s7rmn_jobq #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  clear,
    input  logic                  push,
    input  logic [WIDTH-1:0]      wdata,
    input  logic                  pop,
    output logic [WIDTH-1:0]      rdata,
    output s7rmn_pkg::q_status_t  status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    head_reg, head_next;
    logic [PW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rdata        = entry_reg[head_reg];

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (do_pop)
        begin
            head_next = (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (do_push)
        begin
            tail_next = (tail_reg == PW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else if (clear)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[tail_reg] <= wdata;
        end
    end

endmodule

// ===== sv/s7rmn_front.sv =====
module s7rmn_front #(
    parameter int MAX_GRID = s7rmn_pkg::DEF_MAX_GRID,
    localparam int IDX_W     = $clog2(MAX_GRID),
    localparam int NW        = $clog2(MAX_GRID + 1),
    localparam int NNW       = $clog2(MAX_GRID * MAX_GRID + 1),
    localparam int PW        = $clog2(MAX_GRID * MAX_GRID),
    localparam int WIN_DEPTH = s7rmn_pkg::win_depth(MAX_GRID),
    localparam int SW        = $clog2(WIN_DEPTH),
    localparam int JOB_W     = 3 + 3 * IDX_W + SW
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  clear,
    input  logic [NW-1:0]                         n,
    input  logic [NNW-1:0]                        nn,
    input  logic                                  push,
    output logic                                  full,
    input  logic signed [s7rmn_pkg::FIELD_W-1:0]  diag_coeff,
    input  logic signed [s7rmn_pkg::FIELD_W-1:0]  right_coeff,
    input  logic signed [s7rmn_pkg::FIELD_W-1:0]  up_coeff,
    input  logic signed [s7rmn_pkg::FIELD_W-1:0]  front_coeff,
    input  logic signed [s7rmn_pkg::FIELD_W-1:0]  x_value,
    input  logic signed [s7rmn_pkg::FIELD_W-1:0]  rhs_value,
    input  s7rmn_pkg::q_status_t                  q_status,
    output logic                                  q_push,
    output logic [JOB_W-1:0]                      q_wdata,
    output logic                                  win_we,
    output logic [SW-1:0]                         win_waddr,
    output logic [s7rmn_pkg::CELL_W-1:0]          win_wdata
);

    localparam int FW = s7rmn_pkg::FIELD_W;

    typedef enum logic [1:0] {
        F_ACCEPT,
        F_FLUSH,
        F_FINAL
    } fstate_t;

    fstate_t           state_reg;
    logic [IDX_W-1:0]  wi_reg, wj_reg, wk_reg;
    logic [IDX_W-1:0]  wi_next, wj_next, wk_next;
    logic [IDX_W-1:0]  ji_reg, jj_reg, jk_reg;
    logic [IDX_W-1:0]  ji_next, jj_next, jk_next;
    logic [SW-1:0]     wslot_reg, wslot_next;
    logic [SW-1:0]     jslot_reg, jslot_next;
    logic [PW-1:0]     ppos_reg, ppos_next;
    s7rmn_pkg::err_t   err_reg, err_next;
    logic              right_nz_reg;
    logic [IDX_W-1:0]  n_m1;
    logic [PW-1:0]     nn_m1;
    logic              accept;
    logic              w_last_i, w_last_j, w_last_k, w_last;
    logic              j_last_i, j_last_j, j_last;
    logic              up_nz, plane_nz;
    logic              bad_coupling, bad_zero_diag;
    logic              job_final;

    assign n_m1  = IDX_W'(n - NW'(1));
    assign nn_m1 = PW'(nn - NNW'(1));

    assign full   = (state_reg != F_ACCEPT) || q_status.full;
    assign accept = push && !full;

    assign w_last_i = (wi_reg == n_m1);
    assign w_last_j = (wj_reg == n_m1);
    assign w_last_k = (wk_reg == n_m1);
    assign w_last   = w_last_i && w_last_j && w_last_k;
    assign j_last_i = (ji_reg == n_m1);
    assign j_last_j = (jj_reg == n_m1);
    assign j_last   = j_last_i && j_last_j && (jk_reg == n_m1);

    // raster advance of the write and job positions
    always_comb
    begin
        wi_next    = w_last_i ? '0 : wi_reg + 1'b1;
        wj_next    = w_last_i ? (w_last_j ? '0 : wj_reg + 1'b1) : wj_reg;
        wk_next    = (w_last_i && w_last_j) ? (w_last_k ? '0 : wk_reg + 1'b1) : wk_reg;
        ji_next    = j_last_i ? '0 : ji_reg + 1'b1;
        jj_next    = j_last_i ? (j_last_j ? '0 : jj_reg + 1'b1) : jj_reg;
        jk_next    = (j_last_i && j_last_j) ?
                     ((jk_reg == n_m1) ? '0 : jk_reg + 1'b1) : jk_reg;
        wslot_next = (wslot_reg == SW'(WIN_DEPTH - 1)) ? '0 : wslot_reg + 1'b1;
        jslot_next = (jslot_reg == SW'(WIN_DEPTH - 1)) ? '0 : jslot_reg + 1'b1;
        ppos_next  = (ppos_reg == nn_m1) ? '0 : ppos_reg + 1'b1;
    end

    // nonzero flags of the up and front couplings, one line and one plane back
    s7rmn_ram #(
        .WIDTH (1),
        .DEPTH (MAX_GRID)
    ) u_line_nz (
        .clk   (clk),
        .we    (accept),
        .waddr (wi_reg),
        .wdata (|up_coeff),
        .raddr (accept ? wi_next : wi_reg),
        .rdata (up_nz)
    );

    s7rmn_ram #(
        .WIDTH (1),
        .DEPTH (MAX_GRID * MAX_GRID)
    ) u_plane_nz (
        .clk   (clk),
        .we    (accept),
        .waddr (ppos_reg),
        .wdata (|front_coeff),
        .raddr (accept ? ppos_next : ppos_reg),
        .rdata (plane_nz)
    );

    assign bad_coupling = diag_coeff[FW-1]
                       || (w_last_i && (|right_coeff))
                       || (w_last_j && (|up_coeff))
                       || (w_last_k && (|front_coeff));
    assign bad_zero_diag = (diag_coeff == '0)
                        && ((|rhs_value) || (|right_coeff) || (|up_coeff) || (|front_coeff)
                            || ((wi_reg != '0) && right_nz_reg)
                            || ((wj_reg != '0) && up_nz)
                            || ((wk_reg != '0) && plane_nz));

    always_comb
    begin
        err_next = err_reg;
        if (err_reg == s7rmn_pkg::ERR_NONE)
        begin
            if (bad_coupling)
            begin
                err_next = s7rmn_pkg::ERR_COUPLING;
            end
            else if (bad_zero_diag)
            begin
                err_next = s7rmn_pkg::ERR_ZERO_DIAG;
            end
        end
    end

    assign job_final = (state_reg == F_FINAL);

    always_comb
    begin
        case (state_reg)
            F_ACCEPT: q_push = accept && (wk_reg != '0);
            F_FLUSH:  q_push = !q_status.full;
            F_FINAL:  q_push = !q_status.full;
            default:  q_push = 1'b0;
        endcase
    end

    assign q_wdata = {job_final,
                      job_final ? err_reg : s7rmn_pkg::ERR_NONE,
                      ji_reg, jj_reg, jk_reg, jslot_reg};

    assign win_we    = accept;
    assign win_waddr = wslot_reg;
    always_comb
    begin
        win_wdata = '0;
        win_wdata[s7rmn_pkg::OFS_DIAG  +: FW] = diag_coeff;
        win_wdata[s7rmn_pkg::OFS_RIGHT +: FW] = right_coeff;
        win_wdata[s7rmn_pkg::OFS_UP    +: FW] = up_coeff;
        win_wdata[s7rmn_pkg::OFS_FRONT +: FW] = front_coeff;
        win_wdata[s7rmn_pkg::OFS_X     +: FW] = x_value;
        win_wdata[s7rmn_pkg::OFS_RHS   +: FW] = rhs_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_ACCEPT;
            wi_reg       <= '0;
            wj_reg       <= '0;
            wk_reg       <= '0;
            ji_reg       <= '0;
            jj_reg       <= '0;
            jk_reg       <= '0;
            wslot_reg    <= '0;
            jslot_reg    <= '0;
            ppos_reg     <= '0;
            err_reg      <= s7rmn_pkg::ERR_NONE;
            right_nz_reg <= 1'b0;
        end
        else if (clear)
        begin
            state_reg    <= F_ACCEPT;
            wi_reg       <= '0;
            wj_reg       <= '0;
            wk_reg       <= '0;
            ji_reg       <= '0;
            jj_reg       <= '0;
            jk_reg       <= '0;
            wslot_reg    <= '0;
            jslot_reg    <= '0;
            ppos_reg     <= '0;
            err_reg      <= s7rmn_pkg::ERR_NONE;
            right_nz_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                F_ACCEPT:
                begin
                    if (accept)
                    begin
                        wi_reg       <= wi_next;
                        wj_reg       <= wj_next;
                        wk_reg       <= wk_next;
                        wslot_reg    <= wslot_next;
                        ppos_reg     <= ppos_next;
                        err_reg      <= err_next;
                        right_nz_reg <= |right_coeff;
                        if (q_push)
                        begin
                            ji_reg    <= ji_next;
                            jj_reg    <= jj_next;
                            jk_reg    <= jk_next;
                            jslot_reg <= jslot_next;
                        end
                        if (w_last)
                        begin
                            state_reg <= F_FLUSH;
                        end
                    end
                end
                F_FLUSH:
                begin
                    if (q_push)
                    begin
                        ji_reg    <= ji_next;
                        jj_reg    <= jj_next;
                        jk_reg    <= jk_next;
                        jslot_reg <= jslot_next;
                        if (j_last)
                        begin
                            state_reg <= F_FINAL;
                        end
                    end
                end
                F_FINAL:
                begin
                    if (q_push)
                    begin
                        err_reg   <= s7rmn_pkg::ERR_NONE;
                        state_reg <= F_ACCEPT;
                    end
                end
                default:
                begin
                    state_reg <= F_ACCEPT;
                end
            endcase
        end
    end

endmodule

// ===== sv/s7rmn_back.sv =====
module s7rmn_back #(
    parameter int MAX_GRID      = s7rmn_pkg::DEF_MAX_GRID,
    parameter int FRACTION_BITS = s7rmn_pkg::DEF_FRACTION_BITS,
    localparam int IDX_W     = $clog2(MAX_GRID),
    localparam int NW        = $clog2(MAX_GRID + 1),
    localparam int NNW       = $clog2(MAX_GRID * MAX_GRID + 1),
    localparam int WIN_DEPTH = s7rmn_pkg::win_depth(MAX_GRID),
    localparam int SW        = $clog2(WIN_DEPTH),
    localparam int JOB_W     = 3 + 3 * IDX_W + SW
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 clear,
    input  logic [NW-1:0]                        n,
    input  logic [NNW-1:0]                       nn,
    input  s7rmn_pkg::q_status_t                 q_status,
    input  logic [JOB_W-1:0]                     q_rdata,
    output logic                                 q_pop,
    output logic [SW-1:0]                        win_raddr,
    input  logic [s7rmn_pkg::CELL_W-1:0]         win_rdata,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [s7rmn_pkg::NORM_W-1:0]         residual_norm,
    output logic [1:0]                           status
);

    localparam int FW     = s7rmn_pkg::FIELD_W;
    localparam int PRW    = s7rmn_pkg::PROD_W;
    localparam int AW     = s7rmn_pkg::ACC_W;
    localparam int NRW    = s7rmn_pkg::NORM_W;
    localparam logic [SW:0] DEPTH_X = (SW + 1)'(WIN_DEPTH);

    typedef enum logic [2:0] {
        B_IDLE,
        B_RUN,
        B_DRAIN1,
        B_DRAIN2,
        B_ABS,
        B_NORM
    } bstate_t;

    // one term of the stencil per step
    typedef enum logic [2:0] {
        T_SELF,
        T_LEFT,
        T_RIGHT,
        T_DOWN,
        T_UP,
        T_BACK,
        T_FRONT
    } term_t;

    bstate_t            state_reg;
    term_t              step_reg, s1_step_reg;
    logic               s1_valid_reg, s1_en_reg;
    logic               s2_valid_reg, s2_first_reg;
    logic [IDX_W-1:0]   ci_reg, cj_reg, ck_reg;
    logic [SW-1:0]      cslot_reg;
    logic               out_valid_reg;
    s7rmn_pkg::err_t    status_reg;
    logic [NRW-1:0]     norm_reg;
    logic [NRW-1:0]     max_reg;

    logic signed [FW-1:0]  self_right_reg, self_up_reg, self_front_reg;
    logic signed [AW-1:0]  rhs_sh_reg;
    logic signed [PRW-1:0] prod_reg;
    logic signed [AW-1:0]  acc_reg;
    logic [AW-1:0]         mag_reg;

    logic                  job_last;
    s7rmn_pkg::err_t       job_err;
    logic [IDX_W-1:0]      job_i, job_j, job_k;
    logic [SW-1:0]         job_slot;
    logic [IDX_W-1:0]      n_m1;
    logic [SW-1:0]         off;
    logic                  off_sub, step_en;
    logic [SW:0]           sum_up, sum_dn;
    logic signed [FW-1:0]  rd_diag, rd_right, rd_up, rd_front, rd_x, rd_rhs;
    logic signed [FW-1:0]  coeff;
    logic signed [PRW-1:0] prod_full;
    logic [AW-1:0]         shifted;
    logic [NRW-1:0]        norm_val;

    assign job_last = q_rdata[JOB_W-1];
    assign job_err  = s7rmn_pkg::err_t'(q_rdata[JOB_W-2 -: 2]);
    assign job_i    = q_rdata[SW + 3 * IDX_W - 1 -: IDX_W];
    assign job_j    = q_rdata[SW + 2 * IDX_W - 1 -: IDX_W];
    assign job_k    = q_rdata[SW + IDX_W - 1 -: IDX_W];
    assign job_slot = q_rdata[SW-1:0];
    assign n_m1     = IDX_W'(n - NW'(1));

    assign q_pop = (state_reg == B_IDLE) && !q_status.empty
                && (!job_last || !out_valid_reg);

    // neighbour offset and edge mask of the current step
    always_comb
    begin
        case (step_reg)
            T_SELF:  begin off = '0;      off_sub = 1'b0; step_en = 1'b1;            end
            T_LEFT:  begin off = SW'(1);  off_sub = 1'b1; step_en = (ci_reg != '0);  end
            T_RIGHT: begin off = SW'(1);  off_sub = 1'b0; step_en = (ci_reg != n_m1); end
            T_DOWN:  begin off = SW'(n);  off_sub = 1'b1; step_en = (cj_reg != '0);  end
            T_UP:    begin off = SW'(n);  off_sub = 1'b0; step_en = (cj_reg != n_m1); end
            T_BACK:  begin off = SW'(nn); off_sub = 1'b1; step_en = (ck_reg != '0);  end
            T_FRONT: begin off = SW'(nn); off_sub = 1'b0; step_en = (ck_reg != n_m1); end
            default: begin off = '0;      off_sub = 1'b0; step_en = 1'b0;            end
        endcase
    end

    // circular slot arithmetic, one correction each way
    always_comb
    begin
        sum_up = {1'b0, cslot_reg} + {1'b0, off};
        if (sum_up >= DEPTH_X)
        begin
            sum_up = sum_up - DEPTH_X;
        end
        if (cslot_reg >= off)
        begin
            sum_dn = {1'b0, cslot_reg} - {1'b0, off};
        end
        else
        begin
            sum_dn = {1'b0, cslot_reg} + (DEPTH_X - {1'b0, off});
        end
        win_raddr = off_sub ? sum_dn[SW-1:0] : sum_up[SW-1:0];
    end

    assign rd_diag  = win_rdata[s7rmn_pkg::OFS_DIAG  +: FW];
    assign rd_right = win_rdata[s7rmn_pkg::OFS_RIGHT +: FW];
    assign rd_up    = win_rdata[s7rmn_pkg::OFS_UP    +: FW];
    assign rd_front = win_rdata[s7rmn_pkg::OFS_FRONT +: FW];
    assign rd_x     = win_rdata[s7rmn_pkg::OFS_X     +: FW];
    assign rd_rhs   = win_rdata[s7rmn_pkg::OFS_RHS   +: FW];

    always_comb
    begin
        case (s1_step_reg)
            T_SELF:  coeff = rd_diag;
            T_LEFT:  coeff = rd_right;
            T_RIGHT: coeff = self_right_reg;
            T_DOWN:  coeff = rd_up;
            T_UP:    coeff = self_up_reg;
            T_BACK:  coeff = rd_front;
            T_FRONT: coeff = self_front_reg;
            default: coeff = '0;
        endcase
    end

    // full-width signed product of the coupling and the neighbour's x
    assign prod_full = coeff * rd_x;

    assign shifted  = mag_reg >> FRACTION_BITS;
    assign norm_val = (|shifted[AW-1:NRW]) ? '1 : shifted[NRW-1:0];

    // sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            step_reg      <= T_SELF;
            s1_step_reg   <= T_SELF;
            s1_valid_reg  <= 1'b0;
            s1_en_reg     <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_first_reg  <= 1'b0;
            ci_reg        <= '0;
            cj_reg        <= '0;
            ck_reg        <= '0;
            cslot_reg     <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= s7rmn_pkg::ERR_NONE;
            norm_reg      <= '0;
            max_reg       <= '0;
        end
        else
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= s1_valid_reg;
            s2_first_reg <= (s1_step_reg == T_SELF);
            if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (q_pop)
                    begin
                        if (job_last)
                        begin
                            out_valid_reg <= 1'b1;
                            status_reg    <= job_err;
                            norm_reg      <= (job_err == s7rmn_pkg::ERR_NONE) ? max_reg : '0;
                            max_reg       <= '0;
                        end
                        else
                        begin
                            ci_reg    <= job_i;
                            cj_reg    <= job_j;
                            ck_reg    <= job_k;
                            cslot_reg <= job_slot;
                            step_reg  <= T_SELF;
                            state_reg <= B_RUN;
                        end
                    end
                end
                B_RUN:
                begin
                    s1_valid_reg <= 1'b1;
                    s1_step_reg  <= step_reg;
                    s1_en_reg    <= step_en;
                    if (step_reg == T_FRONT)
                    begin
                        state_reg <= B_DRAIN1;
                    end
                    else
                    begin
                        step_reg <= term_t'(step_reg + 3'd1);
                    end
                end
                B_DRAIN1: state_reg <= B_DRAIN2;
                B_DRAIN2: state_reg <= B_ABS;
                B_ABS:    state_reg <= B_NORM;
                B_NORM:
                begin
                    if (norm_val > max_reg)
                    begin
                        max_reg <= norm_val;
                    end
                    state_reg <= B_IDLE;
                end
                default:  state_reg <= B_IDLE;
            endcase
            if (clear)
            begin
                max_reg <= '0;
            end
        end
    end

    // multiply, accumulate, magnitude
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            prod_reg <= s1_en_reg ? prod_full : '0;
            if (s1_step_reg == T_SELF)
            begin
                self_right_reg <= rd_right;
                self_up_reg    <= rd_up;
                self_front_reg <= rd_front;
                rhs_sh_reg     <= {{(AW - FW){rd_rhs[FW-1]}}, rd_rhs} <<< FRACTION_BITS;
            end
        end
        if (s2_valid_reg)
        begin
            acc_reg <= (s2_first_reg ? rhs_sh_reg : acc_reg)
                     - {{(AW - PRW){prod_reg[PRW-1]}}, prod_reg};
        end
        if (state_reg == B_ABS)
        begin
            mag_reg <= acc_reg[AW-1] ? (~acc_reg + 1'b1) : acc_reg;
        end
    end

    assign empty         = !out_valid_reg;
    assign residual_norm = norm_reg;
    assign status        = status_reg;

endmodule

// ===== sv/stencil7_residual_max_norm.sv =====
// Seven-point stencil residual check with infinity norm over an n-cubed grid.
//
// Configuration: write grid_size (cells per edge) on cfg_wr_data with cfg_wr_en
// high, only while the block is idle. Zero is taken as one, values above
// MAX_GRID as MAX_GRID. A write clears the run in progress. Reset sets min(64, MAX_GRID).
//
// Input queue: present one cell per beat in raster order (i fastest) with push;
// a beat is taken when push is high and full is low. Output queue: after the
// last cell of a grid one result appears while empty is low and leaves on pop.
// While a result waits the next grid still streams in.
//
// Throughput: cells are taken one per cycle until the four-entry job queue
// fills; the checking engine then sets the pace, taking one cell at a time
// through seven reads of the window memory, one multiply and one accumulate
// each, then magnitude and maximum. After the last cell the engine works
// through the final plane, n*n cells, before the result shows; full stays
// high while that final plane is queued.
// A stalled output holds the engine before it would overwrite the waiting
// result; full rises once the job queue is full.
// Reset empties every queue; the window memory needs no clearing pass.
module stencil7_residual_max_norm #(
    parameter int MAX_GRID      = s7rmn_pkg::DEF_MAX_GRID,
    parameter int FRACTION_BITS = s7rmn_pkg::DEF_FRACTION_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [s7rmn_pkg::CFG_W-1:0]           cfg_wr_data,
    input  logic                                  push,
    output logic                                  full,
    input  logic signed [s7rmn_pkg::FIELD_W-1:0]  diag_coeff,
    input  logic signed [s7rmn_pkg::FIELD_W-1:0]  right_coeff,
    input  logic signed [s7rmn_pkg::FIELD_W-1:0]  up_coeff,
    input  logic signed [s7rmn_pkg::FIELD_W-1:0]  front_coeff,
    input  logic signed [s7rmn_pkg::FIELD_W-1:0]  x_value,
    input  logic signed [s7rmn_pkg::FIELD_W-1:0]  rhs_value,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [s7rmn_pkg::NORM_W-1:0]          residual_norm,
    output logic [1:0]                            status
);

    localparam int IDX_W      = $clog2(MAX_GRID);
    localparam int NW         = $clog2(MAX_GRID + 1);
    localparam int NNW        = $clog2(MAX_GRID * MAX_GRID + 1);
    localparam int WIN_DEPTH  = s7rmn_pkg::win_depth(MAX_GRID);
    localparam int SW         = $clog2(WIN_DEPTH);
    localparam int JOB_W      = 3 + 3 * IDX_W + SW;
    localparam int CW         = (NW > s7rmn_pkg::CFG_W) ? NW : s7rmn_pkg::CFG_W;
    localparam int RESET_GRID = (s7rmn_pkg::GRID_RESET > MAX_GRID) ?
                                MAX_GRID : s7rmn_pkg::GRID_RESET;

    // grid size as used, and its square, held for both halves
    logic [NW-1:0]   grid_reg, grid_next;
    logic [NNW-1:0]  plane_reg, plane_next;
    logic [CW-1:0]   cfg_ext;

    assign cfg_ext = CW'(cfg_wr_data);

    always_comb
    begin
        if (cfg_ext == '0)
        begin
            grid_next = NW'(1);
        end
        else if (cfg_ext > CW'(MAX_GRID))
        begin
            grid_next = NW'(MAX_GRID);
        end
        else
        begin
            grid_next = NW'(cfg_ext);
        end
        plane_next = NNW'(grid_next) * NNW'(grid_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_reg  <= NW'(RESET_GRID);
            plane_reg <= NNW'(RESET_GRID * RESET_GRID);
        end
        else if (cfg_wr_en)
        begin
            grid_reg  <= grid_next;
            plane_reg <= plane_next;
        end
    end

    s7rmn_pkg::q_status_t           q_status;
    logic                           q_push, q_pop;
    logic [JOB_W-1:0]               q_wdata, q_rdata;
    logic                           win_we;
    logic [SW-1:0]                  win_waddr, win_raddr;
    logic [s7rmn_pkg::CELL_W-1:0]   win_wdata, win_rdata;

    // front: take cells, check them, store them, issue cell jobs
    s7rmn_front #(
        .MAX_GRID (MAX_GRID)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (cfg_wr_en),
        .n           (grid_reg),
        .nn          (plane_reg),
        .push        (push),
        .full        (full),
        .diag_coeff  (diag_coeff),
        .right_coeff (right_coeff),
        .up_coeff    (up_coeff),
        .front_coeff (front_coeff),
        .x_value     (x_value),
        .rhs_value   (rhs_value),
        .q_status    (q_status),
        .q_push      (q_push),
        .q_wdata     (q_wdata),
        .win_we      (win_we),
        .win_waddr   (win_waddr),
        .win_wdata   (win_wdata)
    );

    // three planes of cells plus slack for the jobs in flight
    s7rmn_ram #(
        .WIDTH (s7rmn_pkg::CELL_W),
        .DEPTH (WIN_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (win_we),
        .waddr (win_waddr),
        .wdata (win_wdata),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

    s7rmn_jobq #(
        .WIDTH (JOB_W),
        .DEPTH (s7rmn_pkg::JOBQ_DEPTH)
    ) u_jobq (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (cfg_wr_en),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .status (q_status)
    );

    // back: residual of each finished cell, running maximum, result beat
    s7rmn_back #(
        .MAX_GRID      (MAX_GRID),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .clear         (cfg_wr_en),
        .n             (grid_reg),
        .nn            (plane_reg),
        .q_status      (q_status),
        .q_rdata       (q_rdata),
        .q_pop         (q_pop),
        .win_raddr     (win_raddr),
        .win_rdata     (win_rdata),
        .empty         (empty),
        .pop           (pop),
        .residual_norm (residual_norm),
        .status        (status)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("job pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("job taken from an empty queue");

    a_error_zero_norm: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != s7rmn_pkg::ERR_NONE) |-> residual_norm == '0)
        else $error("failed grid reports a nonzero norm");

endmodule
